>>> rtl/cdq_pkg.sv
// Shared types and constants for the circular deque.
package cdq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_REAR  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_REAR   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        opcode_t                   opcode;
        logic signed [DATA_W-1:0]  push_value;
    } req_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  pop_value;
        logic [1:0]                status;
        logic [OCC_W-1:0]          occupancy;
    } rsp_word_t;

endpackage

>>> rtl/circular_deque.sv
// Double-ended queue over a circular single-port store of signed words.
//
// Request channel (req_valid, req_stall, req): one word per operation, an
// opcode (push front, push rear, pop front, pop rear) and the value to push.
// Response channel (rsp_valid, rsp_stall, rsp): one word per request, in
// order, with the popped value (zero unless a pop succeeds), a status (ok,
// overflow on a push into a full deque, underflow on a pop from an empty
// one) and the number of stored words after the operation.
// A word moves at a rising edge where valid is high and stall is low.
//
// A push or a failed pop answers in the cycle after acceptance; a
// successful pop answers through the store's registered read port and
// then the response register. Pushes and failed pops run at one
// per cycle while the receiver does not stall; a successful pop holds off
// new requests while its read is in flight.
// The response register holds a finished word while the receiver stalls,
// and a new request is taken as soon as that word leaves.
// Reset empties the deque (both pointers to zero); store contents are not
// cleared and are only read after a push has written them.
module circular_deque
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  cdq_pkg::req_word_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output cdq_pkg::rsp_word_t rsp
);

    logic signed [cdq_pkg::DATA_W-1:0] mem [cdq_pkg::DEPTH];
    logic signed [cdq_pkg::DATA_W-1:0] rd_data_reg;

    logic [cdq_pkg::IDX_W-1:0] head_reg, head_next;
    logic [cdq_pkg::IDX_W-1:0] tail_reg, tail_next;
    logic [cdq_pkg::OCC_W-1:0] count_reg, count_next;

    logic                      pend_reg;
    logic [cdq_pkg::OCC_W-1:0] pend_occ_reg;

    logic                      rsp_valid_reg, rsp_valid_next;
    cdq_pkg::rsp_word_t        rsp_reg, rsp_next;

    logic                      accept;
    logic                      is_empty;
    logic                      is_full;
    logic                      pop_ok;
    logic                      mem_we;
    logic [cdq_pkg::IDX_W-1:0] mem_addr;
    logic                      rsp_free;

    localparam logic [cdq_pkg::IDX_W-1:0] IDX_LAST = cdq_pkg::IDX_W'(cdq_pkg::DEPTH - 1);
    localparam logic [cdq_pkg::OCC_W-1:0] OCC_FULL = cdq_pkg::OCC_W'(cdq_pkg::DEPTH);

    function automatic logic [cdq_pkg::IDX_W-1:0] step_up(input logic [cdq_pkg::IDX_W-1:0] i);
        step_up = (i == IDX_LAST) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [cdq_pkg::IDX_W-1:0] step_down(input logic [cdq_pkg::IDX_W-1:0] i);
        step_down = (i == '0) ? IDX_LAST : i - 1'b1;
    endfunction

    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = pend_reg || !rsp_free;
    assign accept    = req_valid && !req_stall;
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == OCC_FULL);

    // Pointer update and store access for the accepted operation
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        mem_we     = 1'b0;
        mem_addr   = head_reg;
        pop_ok     = 1'b0;
        rsp_next   = '{pop_value: '0, status: cdq_pkg::ST_OK, occupancy: count_reg};
        if (accept)
        begin
            unique case (req.opcode) inside
                cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_REAR:
                begin
                    if (is_full)
                    begin
                        rsp_next.status = cdq_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                        if (is_empty)
                        begin
                            head_next = '0;
                            tail_next = '0;
                            mem_addr  = '0;
                        end
                        else if (req.opcode == cdq_pkg::OP_PUSH_FRONT)
                        begin
                            head_next = step_down(head_reg);
                            mem_addr  = head_next;
                        end
                        else
                        begin
                            tail_next = step_up(tail_reg);
                            mem_addr  = tail_next;
                        end
                        rsp_next.occupancy = count_next;
                    end
                end
                cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_POP_REAR:
                begin
                    if (is_empty)
                    begin
                        rsp_next.status = cdq_pkg::ST_UNDERFLOW;
                    end
                    else
                    begin
                        pop_ok     = 1'b1;
                        count_next = count_reg - 1'b1;
                        mem_addr   = (req.opcode == cdq_pkg::OP_POP_FRONT) ? head_reg : tail_reg;
                        if (head_reg == tail_reg)
                        begin
                            head_next = '0;
                            tail_next = '0;
                        end
                        else if (req.opcode == cdq_pkg::OP_POP_FRONT)
                        begin
                            head_next = step_up(head_reg);
                        end
                        else
                        begin
                            tail_next = step_down(tail_reg);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Response register: load on a direct answer or when the pop read returns
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (pend_reg)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (accept && !pop_ok)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= req.push_value;
        end
        if (pop_ok)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            rsp_reg <= '{pop_value: rd_data_reg, status: cdq_pkg::ST_OK,
                         occupancy: pend_occ_reg};
        end
        else if (accept && !pop_ok)
        begin
            rsp_reg <= rsp_next;
        end
        if (pop_ok)
        begin
            pend_occ_reg <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            pend_reg      <= pop_ok;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
